// ===== rtl/core/mst_pkg.sv =====
// ============================================================================
// mst_pkg
// Shared widths, sizes and register codes of the spanning tree edge selector.
// ============================================================================
package mst_pkg;

    // Largest graph the parent table can hold.
    localparam int C_MAX_VERTICES = 1024;
    localparam int C_VTX_W        = $clog2(C_MAX_VERTICES);
    localparam int C_CNT_W        = C_VTX_W + 1;
    localparam int C_WEIGHT_W     = 32;

    // Stream word: from, to and weight packed from bit 0, padded to bytes.
    localparam int C_FIELDS_W     = 2 * C_VTX_W + C_WEIGHT_W;
    localparam int C_DATA_W       = ((C_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int C_APB_AW       = 3;
    localparam int C_APB_DW       = 32;

    // Register indexes, taken from paddr above the byte offset.
    localparam logic C_REG_VERTEX_COUNT = 1'b0;

    localparam logic [C_CNT_W-1:0] C_VERTEX_COUNT_RST = C_CNT_W'(C_MAX_VERTICES);

endpackage

// ===== rtl/core/mst_edge_selector.sv =====
// Edges are handled one at a time: the input is ready only while idle, and
//   a held output word stalls the link step.
// Reset (synchronous, active low) starts a parent table clearing pass; an
//   edge with start_graph set runs the same pass before it is handled.
// ============================================================================
// mst_edge_selector
// Streaming Kruskal edge selector: a union-find parent table in one memory is
// walked by a single compare unit under a small sequencer.
// ============================================================================
module mst_edge_selector
    import mst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Edge input. tdata from bit 0: from_vertex, to_vertex, edge_weight, pad.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [C_DATA_W-1:0]  i_s_axis_tdata,
    // tuser bit 0: start_graph.
    input  logic                 i_s_axis_tuser,

    // Tree edge output. tdata from bit 0: tree_from, tree_to, tree_weight, pad.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [C_DATA_W-1:0]  o_m_axis_tdata,
    // tlast: tree_complete.
    output logic                 o_m_axis_tlast,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [C_APB_AW-1:0]  paddr,
    input  logic [C_APB_DW-1:0]  pwdata,
    output logic [C_APB_DW-1:0]  prdata,
    output logic                 pready
);

    // The sequencer. CLEAR sweeps the parent table back to "every vertex is
    // its own root". CHECK applies the done flag and the range test. Each walk
    // alternates between a read state and a compare state until the parent
    // read back equals the node itself, which marks the root. LINK joins the
    // two roots, if they differ, and hands the word to the output register.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RD_A,
        S_CMP_A,
        S_RD_B,
        S_CMP_B,
        S_LINK
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_pend, n_pend;
    logic [C_VTX_W-1:0]       r_clr, n_clr;
    logic [C_CNT_W-1:0]       r_count, n_count;
    logic                     r_done, n_done;
    logic [C_CNT_W-1:0]       r_vc;

    logic [C_VTX_W-1:0]       r_from, n_from;
    logic [C_VTX_W-1:0]       r_to, n_to;
    logic [C_WEIGHT_W-1:0]    r_weight, n_weight;
    logic [C_VTX_W-1:0]       r_node, n_node;
    logic [C_VTX_W-1:0]       r_root_a, n_root_a;

    logic                     r_out_valid, n_out_valid;
    logic [C_VTX_W-1:0]       r_out_from, n_out_from;
    logic [C_VTX_W-1:0]       r_out_to, n_out_to;
    logic [C_WEIGHT_W-1:0]    r_out_weight, n_out_weight;
    logic                     r_out_last, n_out_last;

    // Parent table and its port signals.
    logic [C_VTX_W-1:0]       mem [C_MAX_VERTICES];
    logic [C_VTX_W-1:0]       r_rd_data;
    logic                     wr_en;
    logic [C_VTX_W-1:0]       wr_addr;
    logic [C_VTX_W-1:0]       wr_data;

    logic                     in_accept;
    logic                     out_take;
    logic                     out_free;
    logic [C_CNT_W-1:0]       limit;
    logic                     out_of_range;
    logic                     at_root;
    logic                     link_go;
    logic [C_CNT_W-1:0]       count_inc;
    logic                     cfg_wr;

    // ------------------------------------------------------------------
    // Configuration. The single register sits at index 0; a write to the
    // unused index is ignored.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[C_APB_AW-1] == C_REG_VERTEX_COUNT) ?
                    C_APB_DW'(r_vc) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= C_VERTEX_COUNT_RST;
        end else if (cfg_wr && paddr[C_APB_AW-1] == C_REG_VERTEX_COUNT) begin
            r_vc <= pwdata[C_CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and the shared compare unit.
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take        = r_out_valid && i_m_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // A vertex count above the table size behaves as the table size.
    assign limit        = (r_vc > C_CNT_W'(C_MAX_VERTICES)) ?
                          C_CNT_W'(C_MAX_VERTICES) : r_vc;
    assign out_of_range = ({1'b0, r_from} >= limit) || ({1'b0, r_to} >= limit);

    // The one comparator that both walks share.
    assign at_root   = (r_rd_data == r_node);
    assign link_go   = (r_root_a != r_node) && out_free;
    assign count_inc = r_count + C_CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_clr        = r_clr;
        n_count      = r_count;
        n_done       = r_done;
        n_from       = r_from;
        n_to         = r_to;
        n_weight     = r_weight;
        n_node       = r_node;
        n_root_a     = r_root_a;
        n_out_valid  = r_out_valid && !out_take;
        n_out_from   = r_out_from;
        n_out_to     = r_out_to;
        n_out_weight = r_out_weight;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_clr;
        wr_data      = r_clr;

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_clr = r_clr + C_VTX_W'(1);
                if (r_clr == '1) begin
                    n_state = r_pend ? S_CHECK : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_from   = i_s_axis_tdata[C_VTX_W-1:0];
                    n_to     = i_s_axis_tdata[2*C_VTX_W-1:C_VTX_W];
                    n_weight = i_s_axis_tdata[C_FIELDS_W-1:2*C_VTX_W];
                    if (i_s_axis_tuser) begin
                        // A new graph: drop the forest, then handle this edge.
                        n_count = '0;
                        n_done  = 1'b0;
                        n_clr   = '0;
                        n_pend  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_done || out_of_range) begin
                    n_state = S_IDLE;
                end else begin
                    n_node  = r_from;
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                n_state = S_CMP_A;
            end
            S_CMP_A: begin
                if (at_root) begin
                    n_root_a = r_node;
                    n_node   = r_to;
                    n_state  = S_RD_B;
                end else begin
                    n_node  = r_rd_data;
                    n_state = S_RD_A;
                end
            end
            S_RD_B: begin
                n_state = S_CMP_B;
            end
            S_CMP_B: begin
                if (at_root) begin
                    n_state = S_LINK;
                end else begin
                    n_node  = r_rd_data;
                    n_state = S_RD_B;
                end
            end
            S_LINK: begin
                // r_node holds the destination root here.
                if (r_root_a == r_node) begin
                    n_state = S_IDLE;
                end else if (link_go) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_root_a;
                    wr_data      = r_node;
                    n_count      = count_inc;
                    n_out_valid  = 1'b1;
                    n_out_from   = r_from;
                    n_out_to     = r_to;
                    n_out_weight = r_weight;
                    n_out_last   = (count_inc >= limit - C_CNT_W'(1));
                    n_done       = n_out_last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pend      <= 1'b0;
            r_clr       <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_from       <= n_from;
        r_to         <= n_to;
        r_weight     <= n_weight;
        r_node       <= n_node;
        r_root_a     <= n_root_a;
        r_out_from   <= n_out_from;
        r_out_to     <= n_out_to;
        r_out_weight <= n_out_weight;
        r_out_last   <= n_out_last;
    end

    // Parent table: one write port, one registered read port at r_node.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_node];
    end

    // Output word.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = C_DATA_W'({r_out_weight, r_out_to, r_out_from});

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // No edge is taken as the clearing pass after reset begins.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("edge accepted during the clearing pass");

    // The tree can only be complete once at least one edge was counted.
    a_done_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_count != '0))
        else $error("tree marked complete with no accepted edge");

    // Distinct roots imply distinct endpoints in the emitted word.
    a_tree_edge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK && link_go) |=> (r_out_from != r_out_to))
        else $error("self loop emitted as a tree edge");

    // A clearing pass always ends in the last table entry before leaving.
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && n_state != S_CLEAR) |-> (r_clr == '1))
        else $error("clearing pass left early");

endmodule
